[src/bsqrt_pkg.sv]
// Package with the shared constants and types of the fixed-point square root block.
package bsqrt_pkg;

	// Fixed field widths of the channels.
	localparam int RADICAND_W = 32;
	localparam int ROOT_W     = 25;
	localparam int ITER_W     = 6;
	localparam int ACC_W      = 16;

	// Default values of the top-level parameters.
	localparam int MAX_ITER_DEF  = 32;
	localparam int FRAC_BITS_DEF = 16;

	// Reset value of the accuracy register (about 0.001 in Q16.16).
	localparam logic [ACC_W-1:0] ACC_RESET = 16'd66;

	// Saturation limit of the root (256.0 in Q16.16).
	localparam logic [ROOT_W-1:0] ROOT_MAX = 25'd16777216;

	// Decimal first-guess constants.
	localparam int DEC_STEP   = 100;
	localparam int DEC_SPLIT  = 10;

	// One result item.
	typedef struct packed {
		logic [ROOT_W-1:0] root;
		logic              converged;
		logic [ITER_W-1:0] iterations_used;
	} result_t;

endpackage

[src/bsqrt_ifs.sv]
// Valid/ready channel interfaces for the input, result and configuration items.

interface bsqrt_in_if;
	logic                                valid;
	logic                                ready;
	logic [bsqrt_pkg::RADICAND_W-1:0]    radicand;

	modport source (output valid, output radicand, input ready);
	modport sink   (input valid, input radicand, output ready);
endinterface

interface bsqrt_out_if;
	logic                            valid;
	logic                            ready;
	logic [bsqrt_pkg::ROOT_W-1:0]    root;
	logic                            converged;
	logic [bsqrt_pkg::ITER_W-1:0]    iterations_used;

	modport source (output valid, output root, output converged, output iterations_used,
		input ready);
	modport sink   (input valid, input root, input converged, input iterations_used,
		output ready);
endinterface

interface bsqrt_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bsqrt_pkg::ACC_W-1:0]    accuracy;

	modport source (output valid, output accuracy, input ready);
	modport sink   (input valid, input accuracy, output ready);
endinterface

[src/bsqrt_div.sv]
// Restoring unsigned divider that produces one quotient bit per cycle.
module bsqrt_div #(
	parameter int W = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);

	localparam int CW = $clog2(W + 1);

	logic [W:0]    rem_q;
	logic [W-1:0]  dq_q;
	logic [W-1:0]  dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]    trial;
	logic          fits;

	// Shift in the next dividend bit and test whether the divisor fits.
	assign trial = {rem_q[W-1:0], dq_q[W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	// Control: count down the quotient bits and flag the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and the dividend that turns into the quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, dsr_q}) : trial;
			dq_q  <= {dq_q[W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

[src/bsqrt_ctrl.sv]
// Sequencer that runs the first guess and the averaging steps on the shared divider.
module bsqrt_ctrl #(
	parameter int MAX_ITER  = bsqrt_pkg::MAX_ITER_DEF,
	parameter int FRAC_BITS = bsqrt_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [bsqrt_pkg::RADICAND_W-1:0]   radicand,
	input  logic [bsqrt_pkg::ACC_W-1:0]        accuracy,
	output logic                               res_valid,
	input  logic                               res_ready,
	output bsqrt_pkg::result_t                 res
);

	localparam int XW  = bsqrt_pkg::RADICAND_W + FRAC_BITS;
	localparam int IPW = bsqrt_pkg::RADICAND_W - FRAC_BITS;
	localparam int SW  = $clog2(MAX_ITER + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_GUESS = 4'd1;
	localparam logic [3:0] S_LASTQ = 4'd3;
	localparam logic [3:0] S_LASTW = 4'd4;
	localparam logic [3:0] S_STEP  = 4'd5;
	localparam logic [3:0] S_NDIV  = 4'd6;
	localparam logic [3:0] S_XQ    = 4'd7;
	localparam logic [3:0] S_XW    = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;

	logic [3:0]                          state_q;
	logic [bsqrt_pkg::RADICAND_W-1:0]    n_q;
	logic [IPW-1:0]                      ip_q;
	logic [XW-1:0]                       scale_q;
	logic [XW-1:0]                       thr_q;
	logic [XW-1:0]                       mid_q;
	logic [XW-1:0]                       x_q;
	logic [XW-1:0]                       lastq_q;
	logic [SW-1:0]                       steps_q;
	logic                                conv_q;

	logic          div_start;
	logic          div_done;
	logic [XW-1:0] div_dividend;
	logic [XW-1:0] div_divisor;
	logic [XW-1:0] div_quot;

	logic          ip_big;
	logic          at_cap;
	logic          x_zero;
	logic [XW-1:0] guess;
	logic [XW:0]   sum;
	logic [XW-1:0] n_wide;

	// The integer part passes another power of 100 while it reaches the threshold.
	assign ip_big = XW'(ip_q) >= thr_q;
	assign at_cap = steps_q == SW'(MAX_ITER);
	assign x_zero = x_q == '0;
	assign n_wide = {n_q, {FRAC_BITS{1'b0}}};
	assign sum    = {1'b0, x_q} + {1'b0, div_quot};

	// Decimal first guess: 2 or 6 times the power of ten, moved to fixed point.
	// The reduced integer part is below 10 exactly when the full one is below 10 * 100^k.
	always_comb begin
		if (XW'(ip_q) < mid_q) begin
			guess = (scale_q << 1) << FRAC_BITS;
		end else begin
			guess = ((scale_q << 2) + (scale_q << 1)) << FRAC_BITS;
		end
	end

	// Divider operands and launch, chosen by the sequencer state.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = x_q;
		div_divisor  = XW'(accuracy);
		unique case (state_q)
			S_LASTQ: begin
				div_start = 1'b1;
			end
			S_STEP: begin
				div_start    = !at_cap && !x_zero;
				div_dividend = n_wide;
				div_divisor  = x_q;
			end
			S_XQ: begin
				div_start = 1'b1;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	bsqrt_div #(
		.W(XW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_GUESS;
				S_GUESS: if (!ip_big) state_q <= S_LASTQ;
				S_LASTQ: state_q <= S_LASTW;
				S_LASTW: if (div_done) state_q <= S_STEP;
				S_STEP:  state_q <= (at_cap || x_zero) ? S_FIN : S_NDIV;
				S_NDIV:  if (div_done) state_q <= S_XQ;
				S_XQ:    state_q <= S_XW;
				S_XW: begin
					if (div_done) begin
						state_q <= (div_quot == lastq_q) ? S_FIN : S_STEP;
					end
				end
				S_FIN:   if (res_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the current item.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					n_q     <= radicand;
					ip_q    <= radicand[bsqrt_pkg::RADICAND_W-1:FRAC_BITS];
					scale_q <= XW'(1);
					thr_q   <= XW'(bsqrt_pkg::DEC_STEP);
					mid_q   <= XW'(bsqrt_pkg::DEC_SPLIT);
					steps_q <= '0;
				end
			end
			S_GUESS: begin
				if (ip_big) begin
					// Both thresholds grow by 100 and the scale by 10.
					thr_q   <= (thr_q << 6) + (thr_q << 5) + (thr_q << 2);
					mid_q   <= (mid_q << 6) + (mid_q << 5) + (mid_q << 2);
					scale_q <= (scale_q << 3) + (scale_q << 1);
				end else begin
					x_q <= guess;
				end
			end
			S_LASTW: begin
				if (div_done) begin
					lastq_q <= div_quot;
				end
			end
			S_STEP: begin
				// The cap is checked before a zero estimate.
				if (at_cap) begin
					conv_q <= 1'b0;
				end else if (x_zero) begin
					conv_q <= 1'b1;
				end
			end
			S_NDIV: begin
				if (div_done) begin
					x_q     <= sum[XW:1];
					steps_q <= steps_q + 1'b1;
				end
			end
			S_XW: begin
				if (div_done) begin
					lastq_q <= div_quot;
					if (div_quot == lastq_q) begin
						conv_q <= 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = state_q == S_IDLE;
	assign res_valid = state_q == S_FIN;

	// Result with the root saturated at the output range.
	always_comb begin
		if (x_q > XW'(bsqrt_pkg::ROOT_MAX)) begin
			res.root = bsqrt_pkg::ROOT_MAX;
		end else begin
			res.root = x_q[bsqrt_pkg::ROOT_W-1:0];
		end
		res.converged       = conv_q;
		res.iterations_used = bsqrt_pkg::ITER_W'(steps_q);
	end

endmodule

[src/babylonian_sqrt_fixed_point_top.sv]
// Top level of the fixed-point Babylonian square root block.
// Takes one unsigned fixed-point radicand item at a time and returns one result item with
// the root (saturated at 256.0), a converged flag and the number of averaging steps. The
// decimal first guess compares the integer part against growing powers of 100. All
// divisions run on one shared restoring divider of W = 32 + FRAC_BITS bits that yields one
// quotient bit per cycle. The number of averaging steps is at most MAX_ITER, and the default
// format is Q16.16. The input is not ready while an item is in work. The accuracy register is
// written over its own channel, which is always ready, and must only be written while no item
// is in work; a zero accuracy acts as one.
module babylonian_sqrt_fixed_point_top #(
	parameter int MAX_ITER  = bsqrt_pkg::MAX_ITER_DEF,
	parameter int FRAC_BITS = bsqrt_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bsqrt_in_if.sink     req,
	bsqrt_out_if.source  rsp,
	bsqrt_cfg_if.sink    cfg
);

	logic [bsqrt_pkg::ACC_W-1:0] accuracy_q;
	logic [bsqrt_pkg::ACC_W-1:0] acc_eff;
	logic                        res_valid;
	logic                        res_ready;
	bsqrt_pkg::result_t          res;
	bsqrt_pkg::result_t          out_q;
	logic                        out_valid_q;

	// Accuracy register.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accuracy_q <= bsqrt_pkg::ACC_RESET;
		end else if (cfg.valid) begin
			accuracy_q <= cfg.accuracy;
		end
	end

	// A zero accuracy is treated as the finest granularity.
	assign acc_eff = (accuracy_q == '0) ? bsqrt_pkg::ACC_W'(1) : accuracy_q;

	bsqrt_ctrl #(
		.MAX_ITER  (MAX_ITER),
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.radicand  (req.radicand),
		.accuracy  (acc_eff),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: the next item may start while a result waits here.
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.root            = out_q.root;
	assign rsp.converged       = out_q.converged;
	assign rsp.iterations_used = out_q.iterations_used;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the fixed-point Babylonian square root block.
module tb_top;

	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 200;

	// Receiver behavior while a result is offered.
	typedef enum logic [1:0] {RDY_OPEN, RDY_STALL, RDY_JITTER} ready_mode_t;

	// One predicted result together with the radicand that caused it.
	typedef struct {
		logic [bsqrt_pkg::RADICAND_W-1:0] radicand;
		bsqrt_pkg::result_t               result;
	} root_check_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bsqrt_in_if  req_ch();
	bsqrt_out_if rsp_ch();
	bsqrt_cfg_if cfg_ch();

	babylonian_sqrt_fixed_point_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	logic [bsqrt_pkg::RADICAND_W-1:0] pending_radicands[$];
	root_check_t                      expected_roots[$];
	logic [bsqrt_pkg::ACC_W-1:0]      accuracy_reg = bsqrt_pkg::ACC_RESET;
	logic                             item_pending = 1'b0;
	int                               burst_left = 1;
	int                               gap_left = 0;
	int                               ready_hold = 0;
	ready_mode_t                      ready_mode = RDY_OPEN;
	int                               idle_cycles = 0;
	int                               error_count = 0;
	int                               radicands_sent = 0;
	int                               roots_checked = 0;
	int                               capped_roots = 0;
	int                               saturated_roots = 0;
	int                               accuracy_settings = 1;

	always #1 clk = ~clk;

	// Square root by averaging steps from a decimal first guess, as the block computes it.
	function automatic bsqrt_pkg::result_t sqrt_expected(
			input logic [bsqrt_pkg::RADICAND_W-1:0] rad,
			input logic [bsqrt_pkg::ACC_W-1:0] acc_setting);
		bit [63:0]          n;
		bit [63:0]          acc;
		bit [63:0]          ip;
		bit [63:0]          scale;
		bit [63:0]          x;
		bit [63:0]          last_x;
		bit [63:0]          quot;
		int                 steps;
		bit                 done;
		bsqrt_pkg::result_t res;
		n = rad;
		acc = (acc_setting == '0) ? 64'd1 : 64'(acc_setting);
		ip = n >> bsqrt_pkg::FRAC_BITS_DEF;
		scale = 1;
		while (ip >= bsqrt_pkg::DEC_STEP) begin
			ip = ip / bsqrt_pkg::DEC_STEP;
			scale = scale * 10;
		end
		x = ((ip < bsqrt_pkg::DEC_SPLIT) ? 2 * scale : 6 * scale) << bsqrt_pkg::FRAC_BITS_DEF;
		steps = 0;
		done = 1'b0;
		while (!done && steps < bsqrt_pkg::MAX_ITER_DEF) begin
			if (x == 0) begin
				done = 1'b1;
			end else begin
				last_x = x;
				quot = (n << bsqrt_pkg::FRAC_BITS_DEF) / x;
				x = (x + quot) >> 1;
				steps++;
				if (last_x / acc == x / acc)
					done = 1'b1;
			end
		end
		if (x > 64'(bsqrt_pkg::ROOT_MAX))
			x = 64'(bsqrt_pkg::ROOT_MAX);
		res.root = x[bsqrt_pkg::ROOT_W-1:0];
		res.converged = done;
		res.iterations_used = steps[bsqrt_pkg::ITER_W-1:0];
		return res;
	endfunction

	// Random radicand drawn from several classes that stress the guess and the loop.
	function automatic logic [bsqrt_pkg::RADICAND_W-1:0] random_radicand();
		logic [15:0]     ip;
		logic [15:0]     frac;
		longint unsigned m;
		logic [31:0]     rad;
		int              decade;
		frac = 16'($urandom_range(0, 65535));
		ip = '0;
		case ($urandom_range(0, 7))
			0, 7: rad = $urandom;
			1: rad = {16'd0, frac};
			2: rad = {16'($urandom_range(0, 99)), frac};
			3: rad = {16'($urandom_range(100, 9999)), frac};
			4: rad = {16'($urandom_range(10000, 65535)), frac};
			5: begin
				// Integer part right at a decade of the first guess.
				case ($urandom_range(0, 4))
					0: decade = 1;
					1: decade = 10;
					2: decade = 100;
					3: decade = 1000;
					default: decade = 10000;
				endcase
				ip = 16'(decade + $urandom_range(0, 2) - 1);
				rad = {ip, ($urandom_range(0, 1) == 1) ? frac : 16'd0};
			end
			default: begin
				if ($urandom_range(0, 1) == 1) begin
					// Exact square.
					m = $urandom_range(0, 65535);
					rad = 32'(m * m);
				end else begin
					// One below a perfect square of the scaled radicand, where truncation
					// can make the estimate swing between two values.
					m = 64'd32768 * $urandom_range(1, 511);
					m = ($urandom_range(0, 1) == 1) ? m + 1 : m - 1;
					rad = 32'((m * m - 1) >> bsqrt_pkg::FRAC_BITS_DEF);
				end
			end
		endcase
		return rad;
	endfunction

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++)
			pending_radicands = {pending_radicands, random_radicand()};
	endtask

	// Hold off until every queued radicand has gone in and every root has come back.
	task automatic wait_drained();
		while (pending_radicands.size() != 0 || item_pending || expected_roots.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_accuracy(input logic [bsqrt_pkg::ACC_W-1:0] value);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.accuracy <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		accuracy_reg = value;
		accuracy_settings++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Record the expected root of every radicand the block accepts.
	always @(posedge clk) begin : accept_tracker
		root_check_t entry;
		if (arst_n && req_ch.valid && req_ch.ready) begin
			entry.radicand = req_ch.radicand;
			entry.result = sqrt_expected(req_ch.radicand, accuracy_reg);
			if (!entry.result.converged)
				capped_roots++;
			if (entry.result.root == bsqrt_pkg::ROOT_MAX)
				saturated_roots++;
			expected_roots = {expected_roots, entry};
			radicands_sent++;
			item_pending = 1'b0;
		end
	end

	// Sender: bursts of items separated by random gaps, some short, some long.
	always @(negedge clk) begin
		if (arst_n && !item_pending) begin
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
				req_ch.radicand <= $urandom;
			end else if (pending_radicands.size() != 0) begin
				req_ch.valid <= 1'b1;
				req_ch.radicand <= pending_radicands.pop_front();
				item_pending = 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 8);
					if ($urandom_range(0, 9) == 0)
						gap_left = $urandom_range(100, 800);
					else if ($urandom_range(0, 2) == 0)
						gap_left = 0;
					else
						gap_left = $urandom_range(1, 40);
				end
			end else begin
				req_ch.valid <= 1'b0;
				req_ch.radicand <= $urandom;
			end
		end
	end

	// Receiver: long open windows, hard stalls and cycle-by-cycle jitter in random order.
	always @(negedge clk) begin
		if (arst_n) begin
			if (ready_hold == 0) begin
				case ($urandom_range(0, 2))
					0: begin
						ready_mode = RDY_OPEN;
						ready_hold = $urandom_range(1, 300);
					end
					1: begin
						ready_mode = RDY_STALL;
						ready_hold = $urandom_range(1, 40);
					end
					default: begin
						ready_mode = RDY_JITTER;
						ready_hold = $urandom_range(1, 100);
					end
				endcase
			end
			ready_hold--;
			case (ready_mode)
				RDY_OPEN:  rsp_ch.ready <= 1'b1;
				RDY_STALL: rsp_ch.ready <= 1'b0;
				default:   rsp_ch.ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// Compare each root against the oldest expectation.
	always @(posedge clk) begin : root_checker
		root_check_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			roots_checked++;
			if (expected_roots.size() == 0) begin
				$error("unexpected result: root %0d converged %0d iterations_used %0d",
					rsp_ch.root, rsp_ch.converged, rsp_ch.iterations_used);
				error_count++;
			end else begin
				want = expected_roots.pop_front();
				if (rsp_ch.root !== want.result.root) begin
					$error("root: expected %0d, got %0d (radicand 'h%08h)",
						want.result.root, rsp_ch.root, want.radicand);
					error_count++;
				end
				if (rsp_ch.converged !== want.result.converged) begin
					$error("converged: expected %0d, got %0d (radicand 'h%08h)",
						want.result.converged, rsp_ch.converged, want.radicand);
					error_count++;
				end
				if (rsp_ch.iterations_used !== want.result.iterations_used) begin
					$error("iterations_used: expected %0d, got %0d (radicand 'h%08h)",
						want.result.iterations_used, rsp_ch.iterations_used, want.radicand);
					error_count++;
				end
			end
		end
	end

	// Count cycles in which no item moves on any channel.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
	end

	initial begin
		while (idle_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("simulation failed");
		$finish;
	end

	// Phases of stimulus, each under its own accuracy setting.
	initial begin
		req_ch.valid = 1'b0;
		req_ch.radicand = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.accuracy = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset accuracy: field extremes and the decade edges of the first guess.
		pending_radicands = '{32'h0000_0000, 32'h0000_0001, 32'h0000_FFFF, 32'h0001_0000,
			32'h0004_0000, 32'h0009_FFFF, 32'h000A_0000, 32'h0063_FFFF, 32'h0064_0000,
			32'h03E7_0000, 32'h03E8_0000, 32'h270F_FFFF, 32'h2710_0000, 32'hFFFF_0000,
			32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_4001,
			32'h0000_8000};
		queue_random(150);
		wait_drained();

		// Finest granularity: a zero radicand decays to a zero estimate, and a radicand
		// one below a perfect square runs into the step limit.
		write_accuracy(16'd1);
		pending_radicands = '{32'h0000_0000, 32'h0000_4001, 32'hFFFF_FFFF};
		queue_random(80);
		wait_drained();

		// Zero accuracy acts as the finest granularity.
		write_accuracy(16'd0);
		pending_radicands = '{32'h0000_0000, 32'h0000_4001, 32'hFFFF_FFFF};
		queue_random(40);
		wait_drained();

		// Coarsest granularity stops early, so large radicands saturate.
		write_accuracy(16'hFFFF);
		pending_radicands = '{32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_0000};
		queue_random(120);
		wait_drained();

		write_accuracy(16'($urandom_range(1, 65535)));
		queue_random(75);
		wait_drained();
		write_accuracy(16'($urandom_range(2, 15)));
		queue_random(75);
		wait_drained();
		write_accuracy(16'($urandom_range(100, 1000)));
		queue_random(75);
		wait_drained();
		write_accuracy(16'($urandom));
		queue_random(75);
		wait_drained();

		write_accuracy(bsqrt_pkg::ACC_RESET);
		queue_random(50);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d radicands under %0d accuracy settings; %0d roots checked.",
			radicands_sent, accuracy_settings, roots_checked);
		$display("Of those, %0d hit the step limit and %0d saturated at 256.0.",
			capped_roots, saturated_roots);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
